FILE: src/rinv_pkg.sv
// Shared constants and types for the radical inverse sampler.
package rinv_pkg;

   // Sample index width and the most base-b digits it can have (base two)
   localparam int INDEX_BITS       = 64;
   localparam int MAX_DIGITS       = 64;
   localparam int DIGIT_ADDR_BITS  = 6;
   localparam int DIGIT_COUNT_BITS = 7;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_START,
      S_SPLIT,
      S_READ,
      S_HORNER_START,
      S_HORNER_WAIT,
      S_FINISH
   } seq_state_type;

endpackage

FILE: src/rinv_channels.sv
// Valid/ready channel interfaces for the request and response items.
interface rinv_req_if #(
   parameter int BASE_BITS = 8
);
   logic                 valid;
   logic                 ready;
   logic [63:0]          sample_index;
   logic [BASE_BITS-1:0] digit_base;

   modport source (output valid, output sample_index, output digit_base, input ready);
   modport sink   (input valid, input sample_index, input digit_base, output ready);
endinterface

interface rinv_rsp_if #(
   parameter int FRACTION_BITS = 32
);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] fraction;
   logic                     bad_base;

   modport source (output valid, output fraction, output bad_base, input ready);
   modport sink   (input valid, input fraction, input bad_base, output ready);
endinterface

FILE: src/rinv_divider.sv
// Bit-serial restoring divider shared by digit extraction and Horner steps.
module rinv_divider
   import rinv_pkg::*;
#(
   parameter int DIVIDEND_BITS = 64,
   parameter int BASE_BITS     = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [BASE_BITS-1:0]     divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic [BASE_BITS-1:0]     remainder
);

   localparam int COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [BASE_BITS-1:0]     rem_ff, rem_in;
   logic [BASE_BITS-1:0]     div_ff, div_in;
   logic [BASE_BITS:0]       trial;
   logic [BASE_BITS:0]       diff;
   logic                     fits;

   // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = COUNT_BITS'(DIVIDEND_BITS);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DIVIDEND_BITS-2:0], fits};
         rem_in   = fits ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
         count_in = count_ff - COUNT_BITS'(1);
         if (count_ff == COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset; datapath needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/rinv_digit_store.sv
// Digit memory: one write port, one registered read port.
module rinv_digit_store
   import rinv_pkg::*;
#(
   parameter int BASE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [DIGIT_ADDR_BITS-1:0] wr_addr,
   input  logic [BASE_BITS-1:0]       wr_data,
   input  logic                       rd_en,
   input  logic [DIGIT_ADDR_BITS-1:0] rd_addr,
   output logic [BASE_BITS-1:0]       rd_data
);

   logic [BASE_BITS-1:0] mem [MAX_DIGITS];
   logic [BASE_BITS-1:0] rd_data_ff;

   // Store a digit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Fetch a digit
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/radical_inverse_sampler_unit.sv
// Top level: Halton radical inverse sequencer around a shared serial divider.
//
//   channel  dir  handshake        payload
//   req_ch   in   valid / ready    sample_index[63:0], digit_base[BASE_BITS-1:0]
//   rsp_ch   out  valid / ready    fraction[FRACTION_BITS-1:0], bad_base
//
// One item at a time. The single bit-serial divider sets the rate: each division steps
// through D = max(64, BASE_BITS + FRACTION_BITS) quotient bits. An index with n base-b
// digits takes n digit divisions and n Horner divisions (n is at most 64, for base two);
// a zero index or a base below two skips the divider. req_ch.ready is high only while idle; a finished
// item waits in the output register and the next item may be accepted meanwhile.
// Reset (synchronous) clears the sequencer and the output valid; no memory clearing pass.
module radical_inverse_sampler_unit
   import rinv_pkg::*;
#(
   parameter int FRACTION_BITS = 32,
   parameter int BASE_BITS     = 8
) (
   input logic       clock,
   input logic       reset,
   rinv_req_if.sink   req_ch,
   rinv_rsp_if.source rsp_ch
);

   localparam int DIV_BITS = (INDEX_BITS > BASE_BITS + FRACTION_BITS) ?
                             INDEX_BITS : BASE_BITS + FRACTION_BITS;

   seq_state_type state_ff, state_in;

   logic [INDEX_BITS-1:0]       idx_ff, idx_in;
   logic [BASE_BITS-1:0]        base_ff, base_in;
   logic [DIGIT_COUNT_BITS-1:0] count_ff, count_in;
   logic [FRACTION_BITS-1:0]    y_ff, y_in;
   logic                        bad_ff, bad_in;
   logic [FRACTION_BITS-1:0]    fraction_ff, fraction_in;
   logic                        bad_base_ff, bad_base_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        div_start;
   logic [DIV_BITS-1:0]         div_dividend;
   logic                        div_done;
   logic [DIV_BITS-1:0]         div_quot;
   logic [BASE_BITS-1:0]        div_rem;

   logic                        dig_wr_en;
   logic                        dig_rd_en;
   logic [DIGIT_ADDR_BITS-1:0]  dig_rd_addr;
   logic [BASE_BITS-1:0]        dig_rd_data;
   logic [INDEX_BITS-1:0]       next_idx;

   assign next_idx = div_quot[INDEX_BITS-1:0];

   rinv_divider #(
      .DIVIDEND_BITS(DIV_BITS),
      .BASE_BITS    (BASE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (base_ff),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   rinv_digit_store #(
      .BASE_BITS(BASE_BITS)
   ) u_digits (
      .clock  (clock),
      .wr_en  (dig_wr_en),
      .wr_addr(count_ff[DIGIT_ADDR_BITS-1:0]),
      .wr_data(div_rem),
      .rd_en  (dig_rd_en),
      .rd_addr(dig_rd_addr),
      .rd_data(dig_rd_data)
   );

   // Sequence digit extraction, then Horner steps from the top digit down
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      y_in         = y_ff;
      bad_in       = bad_ff;
      fraction_in  = fraction_ff;
      bad_base_in  = bad_base_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      div_dividend = DIV_BITS'(idx_ff);
      dig_wr_en    = 1'b0;
      dig_rd_en    = 1'b0;
      dig_rd_addr  = DIGIT_ADDR_BITS'(count_ff - DIGIT_COUNT_BITS'(1));
      req_ch.ready = 1'b0;

      // Drop the output item once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               idx_in   = req_ch.sample_index;
               base_in  = req_ch.digit_base;
               count_in = '0;
               y_in     = '0;
               bad_in   = (req_ch.digit_base < BASE_BITS'(2));
               if (req_ch.digit_base < BASE_BITS'(2) || req_ch.sample_index == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_DIV_START;
               end
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_SPLIT;
         end
         S_SPLIT: begin
            if (div_done) begin
               dig_wr_en = 1'b1;
               count_in  = count_ff + DIGIT_COUNT_BITS'(1);
               idx_in    = next_idx;
               if (next_idx == '0 ||
                   count_ff == DIGIT_COUNT_BITS'(MAX_DIGITS - 1)) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DIV_START;
               end
            end
         end
         S_READ: begin
            dig_rd_en = 1'b1;
            count_in  = count_ff - DIGIT_COUNT_BITS'(1);
            state_in  = S_HORNER_START;
         end
         S_HORNER_START: begin
            div_start    = 1'b1;
            div_dividend = DIV_BITS'({dig_rd_data, y_ff});
            state_in     = S_HORNER_WAIT;
         end
         S_HORNER_WAIT: begin
            if (div_done) begin
               y_in = div_quot[FRACTION_BITS-1:0];
               if (count_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               fraction_in  = y_ff;
               bad_base_in  = bad_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      base_ff     <= base_in;
      count_ff    <= count_in;
      y_ff        <= y_in;
      bad_ff      <= bad_in;
      fraction_ff <= fraction_in;
      bad_base_ff <= bad_base_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.fraction = fraction_ff;
   assign rsp_ch.bad_base = bad_base_ff;

endmodule

FILE: bench/radical_inverse_sampler_unit_tb.sv
// Self-checking testbench for the radical inverse sampler: directed table, then random items.
module radical_inverse_sampler_unit_tb
   import rinv_pkg::*;
();

   localparam int FRACTION_BITS = 32;
   localparam int BASE_BITS     = 8;
   localparam int RANDOM_ITEMS  = 267;
   localparam int STALL_LIMIT   = 50000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int IDLE_PERCENT  = 9;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] fraction;
      logic                     bad_base;
   } inverse_result_type;

   // One directed item; a typed row carries its expected result, the others use the predictor
   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic [BASE_BITS-1:0]  base;
      logic                  typed;
      inverse_result_type    result;
   } directed_row_type;

   typedef struct packed {
      logic               typed;
      inverse_result_type result;
   } pending_entry_type;

   localparam int DIRECTED_COUNT = 23;

   directed_row_type directed_rows [0:DIRECTED_COUNT-1] = '{
      '{64'h0,                   8'd2,   1'b1, '{32'h0000_0000, 1'b0}},
      '{64'h0,                   8'd255, 1'b1, '{32'h0000_0000, 1'b0}},
      '{64'h0,                   8'd0,   1'b1, '{32'h0000_0000, 1'b1}},
      '{64'h5,                   8'd1,   1'b1, '{32'h0000_0000, 1'b1}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd0,   1'b1, '{32'h0000_0000, 1'b1}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd1,   1'b1, '{32'h0000_0000, 1'b1}},
      '{64'h1,                   8'd2,   1'b1, '{32'h8000_0000, 1'b0}},
      '{64'h2,                   8'd2,   1'b1, '{32'h4000_0000, 1'b0}},
      '{64'h3,                   8'd2,   1'b1, '{32'hC000_0000, 1'b0}},
      '{64'h1,                   8'd3,   1'b1, '{32'h5555_5555, 1'b0}},
      '{64'h2,                   8'd3,   1'b1, '{32'hAAAA_AAAA, 1'b0}},
      '{64'h1,                   8'd255, 1'b1, '{32'h0101_0101, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd2,   1'b1, '{32'hFFFF_FFFF, 1'b0}},
      '{64'h8000_0000_0000_0000, 8'd2,   1'b1, '{32'h0000_0000, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd3,   1'b0, '{32'h0, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b0, '{32'h0, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 8'd254, 1'b0, '{32'h0, 1'b0}},
      '{64'hFE,                  8'd255, 1'b0, '{32'h0, 1'b0}},
      '{64'hFF,                  8'd255, 1'b0, '{32'h0, 1'b0}},
      '{64'h5555_5555_5555_5555, 8'd2,   1'b0, '{32'h0, 1'b0}},
      '{64'hAAAA_AAAA_AAAA_AAAA, 8'd128, 1'b0, '{32'h0, 1'b0}},
      '{64'h0123_4567_89AB_CDEF, 8'd7,   1'b0, '{32'h0, 1'b0}},
      '{64'h0000_0001_0000_0000, 8'd13,  1'b0, '{32'h0, 1'b0}}
   };

   logic [7:0] small_primes [0:8] = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17,
                                      8'd19, 8'd23};

   logic clock;
   logic reset;
   bit   idling_on = 1'b1;
   int   error_count = 0;
   int   quiet_cycles = 0;

   pending_entry_type  typed_expectations [$];
   inverse_result_type expected_results [$];

   rinv_req_if #(.BASE_BITS(BASE_BITS))         req_ch ();
   rinv_rsp_if #(.FRACTION_BITS(FRACTION_BITS)) rsp_ch ();

   radical_inverse_sampler_unit #(
      .FRACTION_BITS (FRACTION_BITS),
      .BASE_BITS     (BASE_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mirror the base-b digits about the radix point, truncated to the fraction width
   function automatic inverse_result_type compute_radical_inverse(
      input logic [INDEX_BITS-1:0] index,
      input logic [BASE_BITS-1:0]  base
   );
      logic [BASE_BITS-1:0] digits [0:MAX_DIGITS-1];
      logic [63:0]          rest;
      logic [63:0]          partial;
      logic [63:0]          quotient;
      int                   count;
      inverse_result_type   result;
      result.fraction = '0;
      result.bad_base = 1'b0;
      if (base < 2) begin
         result.bad_base = 1'b1;
         return result;
      end
      rest  = index;
      count = 0;
      while (rest != 0) begin
         digits[count] = BASE_BITS'(rest % base);
         rest          = rest / base;
         count++;
      end
      // Horner from the least significant mirrored digit up, truncating at each step
      for (int k = count - 1; k >= 0; k--) begin
         partial         = (64'(digits[k]) << FRACTION_BITS) | 64'(result.fraction);
         quotient        = partial / 64'(base);
         result.fraction = quotient[FRACTION_BITS-1:0];
      end
      return result;
   endfunction

   // Present one item and hold it until the block takes it
   task automatic send_sample(
      input logic [INDEX_BITS-1:0] index,
      input logic [BASE_BITS-1:0]  base,
      input logic                  typed,
      input inverse_result_type    result
   );
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      typed_expectations.push_back('{typed, result});
      req_ch.valid        <= 1'b1;
      req_ch.sample_index <= index;
      req_ch.digit_base   <= base;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_for_results;
      while (typed_expectations.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Throttle the result side
   always @(posedge clock) begin
      rsp_ch.ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
   end

   // Check results, record accepted items and watch for a hang
   always @(posedge clock) begin
      inverse_result_type actual;
      inverse_result_type wanted;
      pending_entry_type  entry;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            actual.fraction = rsp_ch.fraction;
            actual.bad_base = rsp_ch.bad_base;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual fraction %h bad_base %b",
                        $time, actual.fraction, actual.bad_base);
               error_count++;
            end else begin
               wanted = expected_results.pop_front();
               if (actual.fraction !== wanted.fraction) begin
                  $display("%0t: fraction mismatch, expected %h, actual %h",
                           $time, wanted.fraction, actual.fraction);
                  error_count++;
               end
               if (actual.bad_base !== wanted.bad_base) begin
                  $display("%0t: bad_base mismatch, expected %b, actual %b",
                           $time, wanted.bad_base, actual.bad_base);
                  error_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            entry = typed_expectations.pop_front();
            if (entry.typed)
               expected_results.push_back(entry.result);
            else
               expected_results.push_back(
                  compute_radical_inverse(req_ch.sample_index, req_ch.digit_base));
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      logic [INDEX_BITS-1:0] index;
      logic [BASE_BITS-1:0]  base;
      int unsigned           pick;
      int unsigned           width;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.sample_index <= '0;
      req_ch.digit_base   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[r])
         send_sample(directed_rows[r].index, directed_rows[r].base,
                     directed_rows[r].typed, directed_rows[r].result);

      // Random items: mostly short indexes, a few full width
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 140) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            wait_for_results();
         end
         if (i == 170) idling_on <= 1'b0;
         if (i == 240) idling_on <= 1'b1;
         pick = $urandom_range(99);
         if (pick < 60)
            width = $urandom_range(1, 12);
         else if (pick < 85)
            width = $urandom_range(13, 32);
         else
            width = INDEX_BITS;
         index = {$urandom, $urandom};
         if (width < INDEX_BITS)
            index &= (64'd1 << width) - 64'd1;
         pick = $urandom_range(99);
         if (pick < 5)
            base = BASE_BITS'($urandom_range(1));
         else if (pick < 60)
            base = BASE_BITS'(small_primes[$urandom_range(8)]);
         else
            base = BASE_BITS'($urandom_range(2, 255));
         send_sample(index, base, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);

      // Drain, then give stray results time to show up
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
